// File: sv/uers_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ultrasonic echo ranging sequencer.
// No dependencies; used by the top level and its checker.
package uers_pkg;

    typedef enum logic [3:0] {
        ST_READY = 4'd0,
        ST_TRIG  = 4'd1,
        ST_WAIT  = 4'd2,
        ST_RISE  = 4'd3,
        ST_FALL  = 4'd4,
        ST_CAPT  = 4'd5,
        ST_CALC  = 4'd6,
        ST_DONE  = 4'd7,
        ST_TOUT  = 4'd8
    } t_stage;

    typedef enum logic {
        CMD_STEP = 1'b0,
        CMD_CAPT = 1'b1
    } t_cmd;

    // Configuration register indexes
    localparam logic [1:0] CFG_RISE_CH = 2'd0;
    localparam logic [1:0] CFG_FALL_CH = 2'd1;
    localparam logic [1:0] CFG_GAP     = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [1:0]  RISE_CH_RST = 2'd0;
    localparam logic [1:0]  FALL_CH_RST = 2'd1;
    localparam logic [23:0] GAP_RST     = 24'd60000;
    localparam logic [23:0] TIMEOUT_RST = 24'd30000;

    // floor(d*5/29) = (d * 5 * ceil(2^24/29)) >> 24 for every 16-bit d
    localparam int          RECIP_SHIFT = 24;
    localparam logic [21:0] RANGE_MULT  = 22'd2892625;
    localparam int          PROD_W      = 38;

    localparam logic [13:0] RANGE_MAX   = 14'd11299;

endpackage

// File: sv/ultrasonic_echo_ranging_sequencer_top.sv
`timescale 1ns / 1ps
// Ultrasonic echo ranging sequencer: stage machine, capture stamps, range math.
// Depends on uers_pkg.
//
//  channel | handshake                    | payload
//  --------+------------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_stall      | i_cmd, i_now_us, i_chan, i_stamp
//  out     | o_out_valid / i_out_stall    | o_stage, o_distance_mm, o_trig_fire,
//          |                              | o_capture_armed
//  cfg     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One request per cycle while the output is not stalled; each request passes the input
// register, then the result register. The range multiply and the elapsed-time
// compare sit between those two registers. Synchronous active-low reset clears the
// sequencer state and the config registers to their defaults. An output stall holds
// the result register and backs up into the input register.
module ultrasonic_echo_ranging_sequencer_top
    import uers_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_now_us,
    input  logic [1:0]  i_chan,
    input  logic [15:0] i_stamp,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_stage,
    output logic [13:0] o_distance_mm,
    output logic        o_trig_fire,
    output logic        o_capture_armed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // Config
    logic [1:0]  r_rise_ch, r_fall_ch;
    logic [23:0] r_gap, r_timeout;

    // Input register
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [31:0] r_in_now;
    logic [1:0]  r_in_chan;
    logic [15:0] r_in_stamp;

    // Sequencer state
    t_stage      r_stage, n_stage;
    logic [31:0] r_mark, n_mark;
    logic [15:0] r_rise, n_rise;
    logic [15:0] r_fall, n_fall;
    logic [13:0] r_range, n_range;
    logic        r_armed, n_armed;
    logic        n_fire;

    // Result register
    logic        r_out_valid;
    logic [3:0]  r_out_stage;
    logic [13:0] r_out_dist;
    logic        r_out_fire;
    logic        r_out_armed;

    logic              advance;
    logic              load_in;
    logic [31:0]       elapsed;
    logic              gap_met;
    logic              timed_out;
    logic [15:0]       diff;
    logic [PROD_W-1:0] prod;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign load_in    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign elapsed   = r_in_now - r_mark;
    assign gap_met   = elapsed >= {8'd0, r_gap};
    assign timed_out = elapsed > {8'd0, r_timeout};
    assign diff      = r_fall - r_rise;
    assign prod      = {{(PROD_W-16){1'b0}}, diff} * {{(PROD_W-22){1'b0}}, RANGE_MULT};

    always_comb begin
        n_stage = r_stage;
        n_mark  = r_mark;
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_range = r_range;
        n_armed = r_armed;
        n_fire  = 1'b0;
        if (r_in_cmd == CMD_CAPT) begin
            if (r_stage inside {ST_WAIT, ST_RISE, ST_FALL}) begin
                // rise channel wins when both channels match
                if (r_in_chan == r_rise_ch) begin
                    n_rise = r_in_stamp;
                end else if (r_in_chan == r_fall_ch) begin
                    n_fall = r_in_stamp;
                end
            end
        end else begin
            case (r_stage)
                ST_READY: begin
                    if (gap_met) n_stage = ST_TRIG;
                end
                ST_TRIG: begin
                    n_rise  = '0;
                    n_fall  = '0;
                    n_fire  = 1'b1;
                    n_armed = 1'b1;
                    n_mark  = r_in_now;
                    n_stage = ST_WAIT;
                end
                ST_WAIT: n_stage = ST_RISE;
                ST_RISE: begin
                    // a seen stamp beats the timeout
                    if (r_rise != '0) n_stage = ST_FALL;
                    else if (timed_out) n_stage = ST_TOUT;
                end
                ST_FALL: begin
                    if (r_fall != '0) n_stage = ST_CAPT;
                    else if (timed_out) n_stage = ST_TOUT;
                end
                ST_CAPT: begin
                    n_armed = 1'b0;
                    n_stage = ST_CALC;
                end
                ST_CALC: begin
                    n_range = prod[RECIP_SHIFT +: 14];
                    n_stage = ST_DONE;
                end
                ST_DONE: begin
                    n_mark  = r_in_now;
                    n_stage = ST_READY;
                end
                ST_TOUT: begin
                    n_armed = 1'b0;
                    n_mark  = r_in_now;
                    n_stage = ST_READY;
                end
                default: n_stage = r_stage;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_ch <= RISE_CH_RST;
            r_fall_ch <= FALL_CH_RST;
            r_gap     <= GAP_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RISE_CH: r_rise_ch <= i_cfg_data[1:0];
                CFG_FALL_CH: r_fall_ch <= i_cfg_data[1:0];
                CFG_GAP:     r_gap     <= i_cfg_data;
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                default:     r_gap     <= r_gap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in_cmd   <= i_cmd;
            r_in_now   <= i_now_us;
            r_in_chan  <= i_chan;
            r_in_stamp <= i_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_READY;
            r_mark      <= '0;
            r_rise      <= '0;
            r_fall      <= '0;
            r_range     <= '0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_stage <= n_stage;
                r_mark  <= n_mark;
                r_rise  <= n_rise;
                r_fall  <= n_fall;
                r_range <= n_range;
                r_armed <= n_armed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_stage <= n_stage;
            r_out_dist  <= n_range;
            r_out_fire  <= n_fire;
            r_out_armed <= n_armed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stage         = r_out_stage;
    assign o_distance_mm   = r_out_dist;
    assign o_trig_fire     = r_out_fire;
    assign o_capture_armed = r_out_armed;

endmodule

// File: sv/uers_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the ranging sequencer, bound to the top level.
// Depends on uers_pkg and ultrasonic_echo_ranging_sequencer_top.
module uers_checker
    import uers_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_stage,
    input logic [13:0] o_distance_mm,
    input logic        o_trig_fire,
    input logic        o_capture_armed
);

    // Trigger always lands the sequencer in the wait stage with capture armed
    a_fire_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_trig_fire |-> o_stage == ST_WAIT && o_capture_armed)
        else $error("trigger fired without arming");

    // Capture is armed exactly from trigger through captured or timeout
    a_armed_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_capture_armed == (o_stage == ST_WAIT || o_stage == ST_RISE
            || o_stage == ST_FALL || o_stage == ST_CAPT || o_stage == ST_TOUT))
        else $error("capture armed outside the echo window");

    a_range_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_distance_mm <= RANGE_MAX)
        else $error("distance beyond sensor range");

    // Distance only changes on leaving the calc stage
    a_dist_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid && o_stage != ST_DONE
            |-> $stable(o_distance_mm))
        else $error("distance changed outside calc");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_stage)
            && $stable(o_distance_mm))
        else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranging_sequencer_top uers_checker u_uers_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for ultrasonic_echo_ranging_sequencer_top: directed stage walks, then randomized
// measurement sequences under sender gaps and receiver stalls. Depends on uers_pkg.
module testbench;
    import uers_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_stage      stage;
        logic [13:0] dist_mm;
        logic        fire;
        logic        armed;
    } t_echo_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_cmd;
    logic [31:0] i_now_us;
    logic [1:0]  i_chan;
    logic [15:0] i_stamp;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_stage;
    logic [13:0] o_distance_mm;
    logic        o_trig_fire;
    logic        o_capture_armed;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    ultrasonic_echo_ranging_sequencer_top dut (.*);

    // Expected sequencer state and register copies
    t_stage      seq_stage;
    logic [31:0] seq_mark;
    logic [15:0] seq_rise;
    logic [15:0] seq_fall;
    logic [13:0] seq_range;
    logic        seq_armed;
    logic [1:0]  cf_rise_ch;
    logic [1:0]  cf_fall_ch;
    logic [23:0] cf_gap;
    logic [23:0] cf_timeout;

    t_echo_result pending_echoes[$];
    t_echo_result want;

    logic [31:0] now_t;
    bit          tmo_mode;
    int          wait_steps;
    int          stall_pct;
    int          gap_max;
    int          burst_left;
    int          stall_run;
    int          errors;
    int          cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_echoes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver stall pattern: runs of stalled or open cycles
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_run   <= $urandom_range(0, 5);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_echoes.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual stage %0d dist %0d",
                         $time, o_stage, o_distance_mm);
                errors++;
            end else begin
                want = pending_echoes.pop_front();
                if (o_stage !== want.stage) begin
                    $display("%0t: stage mismatch: expected %0d, actual %0d",
                             $time, want.stage, o_stage);
                    errors++;
                end
                if (o_distance_mm !== want.dist_mm) begin
                    $display("%0t: distance mismatch: expected %0d, actual %0d",
                             $time, want.dist_mm, o_distance_mm);
                    errors++;
                end
                if (o_trig_fire !== want.fire) begin
                    $display("%0t: trig_fire mismatch: expected %0b, actual %0b",
                             $time, want.fire, o_trig_fire);
                    errors++;
                end
                if (o_capture_armed !== want.armed) begin
                    $display("%0t: capture_armed mismatch: expected %0b, actual %0b",
                             $time, want.armed, o_capture_armed);
                    errors++;
                end
            end
        end
    end

    task automatic advance_ranging(input t_cmd cmd, input logic [31:0] now,
                                   input logic [1:0] chan, input logic [15:0] stamp);
        logic [31:0]  elapsed;
        logic [15:0]  diff;
        int unsigned  span;
        logic         fire;
        t_echo_result res;
        elapsed = now - seq_mark;
        diff    = seq_fall - seq_rise;
        fire    = 1'b0;
        if (cmd == CMD_CAPT) begin
            // the stage decides, not the armed bit
            if (seq_stage == ST_WAIT || seq_stage == ST_RISE || seq_stage == ST_FALL) begin
                if (chan == cf_rise_ch)
                    seq_rise = stamp;
                else if (chan == cf_fall_ch)
                    seq_fall = stamp;
            end
        end else begin
            case (seq_stage)
                ST_READY: begin
                    if (elapsed >= {8'd0, cf_gap})
                        seq_stage = ST_TRIG;
                end
                ST_TRIG: begin
                    seq_rise  = '0;
                    seq_fall  = '0;
                    fire      = 1'b1;
                    seq_armed = 1'b1;
                    seq_mark  = now;
                    seq_stage = ST_WAIT;
                end
                ST_WAIT: seq_stage = ST_RISE;
                ST_RISE: begin
                    if (elapsed > {8'd0, cf_timeout})
                        seq_stage = ST_TOUT;
                    if (seq_rise != '0)
                        seq_stage = ST_FALL;
                end
                ST_FALL: begin
                    if (elapsed > {8'd0, cf_timeout})
                        seq_stage = ST_TOUT;
                    if (seq_fall != '0)
                        seq_stage = ST_CAPT;
                end
                ST_CAPT: begin
                    seq_armed = 1'b0;
                    seq_stage = ST_CALC;
                end
                ST_CALC: begin
                    span      = (32'(diff) * 5) / 29;
                    seq_range = span[13:0];
                    seq_stage = ST_DONE;
                end
                ST_DONE: begin
                    seq_mark  = now;
                    seq_stage = ST_READY;
                end
                ST_TOUT: begin
                    seq_armed = 1'b0;
                    seq_mark  = now;
                    seq_stage = ST_READY;
                end
                default: ;
            endcase
        end
        res.stage   = seq_stage;
        res.dist_mm = seq_range;
        res.fire    = fire;
        res.armed   = seq_armed;
        pending_echoes.push_back(res);
    endtask

    task automatic send_req(input t_cmd cmd, input logic [31:0] now,
                            input logic [1:0] chan, input logic [15:0] stamp);
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_now_us   <= now;
        i_chan     <= chan;
        i_stamp    <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        advance_ranging(cmd, now, chan, stamp);
    endtask

    // Send one request, then maybe close the burst with an idle gap
    task automatic issue_item(input t_cmd cmd, input logic [31:0] now,
                              input logic [1:0] chan, input logic [15:0] stamp);
        int n;
        send_req(cmd, now, chan, stamp);
        if (cmd == CMD_STEP)
            now_t = now;
        burst_left--;
        if (burst_left <= 0) begin
            n = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (n > 0) begin
                i_in_valid <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain_results();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (pending_echoes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [1:0] rise_ch, input logic [1:0] fall_ch,
                              input logic [23:0] gap, input logic [23:0] tmo);
        logic [1:0]  idx;
        logic [23:0] data;
        drain_results();
        for (int k = 0; k < 4; k++) begin
            idx = k[1:0];
            case (idx)
                CFG_RISE_CH: data = {22'd0, rise_ch};
                CFG_FALL_CH: data = {22'd0, fall_ch};
                CFG_GAP:     data = gap;
                default:     data = tmo;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                CFG_RISE_CH: cf_rise_ch = data[1:0];
                CFG_FALL_CH: cf_fall_ch = data[1:0];
                CFG_GAP:     cf_gap     = data;
                default:     cf_timeout = data;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Full measurement at reset settings, ending on the widest pulse
    task automatic test_default_cycle();
        stall_pct = 25;
        gap_max   = 3;
        issue_item(CMD_CAPT, $urandom, 2'd0, 16'd5);       // outside echo wait: dropped
        issue_item(CMD_STEP, 32'd59999, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'd60000, 2'd3, 16'hFFFF);
        issue_item(CMD_STEP, 32'd60001, 2'd1, 16'd0);
        issue_item(CMD_CAPT, $urandom, 2'd1, 16'hFFFF);
        issue_item(CMD_CAPT, $urandom, 2'd0, 16'd0);       // zero stamp is not an edge
        issue_item(CMD_STEP, 32'd60005, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'd90001, 2'd0, 16'd0);      // exactly at the timeout
        issue_item(CMD_CAPT, $urandom, 2'd0, 16'd2);
        issue_item(CMD_CAPT, $urandom, 2'd1, 16'd1);
        issue_item(CMD_STEP, 32'd90002, 2'd0, 16'd0);      // seen stamp beats timeout
        issue_item(CMD_STEP, 32'd90003, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'd90004, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'd90005, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'd90010, 2'd0, 16'd0);
    endtask

    // Both edges on one channel, zero gap and zero timeout, time wrap
    task automatic test_shared_channel();
        write_regs(2'd3, 2'd3, 24'd0, 24'd0);
        issue_item(CMD_STEP, now_t + 1, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'hFFFF_FFFF, 2'd0, 16'd0);
        issue_item(CMD_CAPT, $urandom, 2'd3, 16'd7);
        issue_item(CMD_CAPT, $urandom, 2'd2, 16'd9);       // unmatched channel
        issue_item(CMD_STEP, 32'd0, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'd1, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'd2, 2'd0, 16'd0);
        issue_item(CMD_STEP, 32'd3, 2'd0, 16'd0);
    endtask

    // One request steered by the expected stage; mostly well-formed measurements
    task automatic random_item(output bit counted);
        int          r;
        int          lim;
        logic [15:0] stamp;
        logic [1:0]  ch;
        r       = $urandom_range(0, 99);
        stamp   = 16'($urandom);
        ch      = 2'($urandom);
        counted = 1'b1;
        case (seq_stage)
            ST_READY: begin
                if (r < 8) begin
                    counted = 1'b0;
                    issue_item(CMD_CAPT, $urandom, ch, stamp);
                end else if (r < 14) begin
                    issue_item(CMD_STEP, $urandom, ch, stamp);
                end else if (r < 30 && cf_gap != 0) begin
                    issue_item(CMD_STEP, seq_mark + cf_gap - 1, ch, stamp);
                end else begin
                    issue_item(CMD_STEP, seq_mark + cf_gap + $urandom_range(0, 3), ch, stamp);
                end
            end
            ST_TRIG: begin
                tmo_mode   = (r < 20);
                wait_steps = 0;
                issue_item(CMD_STEP, now_t + $urandom_range(0, 30), ch, stamp);
            end
            ST_WAIT, ST_RISE, ST_FALL: begin
                if (r < 30) begin
                    if (stamp == 0 && $urandom_range(0, 3) != 0)
                        stamp = 16'(1 + $urandom_range(0, 65534));
                    issue_item(CMD_CAPT, $urandom,
                               (seq_stage == ST_FALL) ? cf_fall_ch : cf_rise_ch, stamp);
                end else if (r < 42) begin
                    issue_item(CMD_CAPT, $urandom, ch, stamp);
                end else begin
                    wait_steps++;
                    // give up on echoes that cannot arrive
                    if (wait_steps > 12)
                        tmo_mode = 1'b1;
                    if (tmo_mode) begin
                        issue_item(CMD_STEP, seq_mark + cf_timeout + $urandom_range(0, 1),
                                   ch, stamp);
                    end else begin
                        lim = (cf_timeout < 40) ? cf_timeout / 4 : 10;
                        issue_item(CMD_STEP, now_t + $urandom_range(0, lim), ch, stamp);
                    end
                end
            end
            default: begin
                if (r < 10) begin
                    counted = 1'b0;
                    issue_item(CMD_CAPT, $urandom, ch, stamp);
                end else begin
                    issue_item(CMD_STEP, now_t + $urandom_range(0, 30), ch, stamp);
                end
            end
        endcase
    endtask

    task automatic run_phase(input logic [1:0] rise_ch, input logic [1:0] fall_ch,
                             input logic [23:0] gap, input logic [23:0] tmo,
                             input int stall, input int gaps, input int n, input bit pause);
        int moved;
        bit counted;
        moved = 0;
        write_regs(rise_ch, fall_ch, gap, tmo);
        stall_pct = stall;
        gap_max   = gaps;
        while (moved < n) begin
            random_item(counted);
            if (counted)
                moved++;
            // hold off the sender until every result is back
            if (pause && moved == n / 2)
                drain_results();
        end
    endtask

    task automatic test_random_phases();
        logic [1:0] ch;
        ch = 2'($urandom);
        run_phase(2'd0, 2'd1, 24'd0, 24'hFFFFFF, 0, 0, 100, 1'b0);
        run_phase(2'($urandom), 2'($urandom), 24'hFFFFFF, 24'd0, 40, 6, 100, 1'b0);
        run_phase(2'($urandom), 2'($urandom), 24'($urandom_range(0, 500)),
                  24'($urandom_range(0, 300)), 60, 10, 110, 1'b1);
        run_phase(ch, ch, 24'($urandom_range(0, 100)), 24'($urandom), 20, 3, 100, 1'b0);
        run_phase(2'($urandom), 2'($urandom), 24'($urandom), 24'($urandom), 50, 8, 110, 1'b0);
        run_phase(RISE_CH_RST, FALL_CH_RST, GAP_RST, TIMEOUT_RST, 30, 4, 100, 1'b0);
    endtask

    initial begin
        errors      = 0;
        cycles      = 0;
        stall_pct   = 0;
        gap_max     = 0;
        burst_left  = 1;
        stall_run   = 0;
        tmo_mode    = 1'b0;
        wait_steps  = 0;
        now_t       = '0;
        seq_stage   = ST_READY;
        seq_mark    = '0;
        seq_rise    = '0;
        seq_fall    = '0;
        seq_range   = '0;
        seq_armed   = 1'b0;
        cf_rise_ch  = RISE_CH_RST;
        cf_fall_ch  = FALL_CH_RST;
        cf_gap      = GAP_RST;
        cf_timeout  = TIMEOUT_RST;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_STEP;
        i_now_us    <= '0;
        i_chan      <= '0;
        i_stamp     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_cycle();
        test_shared_channel();
        test_random_phases();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
sv/uers_pkg.sv
sv/ultrasonic_echo_ranging_sequencer_top.sv
sv/uers_checker.sv
verif/testbench.sv
